[rtl/hpid_pkg.sv]
// Shared types and constants of the heater PID controller.
`timescale 1ns / 1ps
`default_nettype none

package hpid_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_DT,
        ST_MUL_PS,
        ST_DIV_LOAD,
        ST_DIV,
        ST_MUL_ERR,
        ST_MUL_KP,
        ST_MUL_KIL,
        ST_MUL_KIH,
        ST_MUL_KD,
        ST_FIN
    } state_t;

    // Register indexes of the write port
    localparam logic [2:0] CFG_KP        = 3'd0;
    localparam logic [2:0] CFG_KI        = 3'd1;
    localparam logic [2:0] CFG_KD        = 3'd2;
    localparam logic [2:0] CFG_OUT_MIN   = 3'd3;
    localparam logic [2:0] CFG_OUT_MAX   = 3'd4;
    localparam logic [2:0] CFG_MIN_DT    = 3'd5;
    localparam logic [2:0] CFG_INT_LIMIT = 3'd6;
    localparam logic [2:0] CFG_SETTLE    = 3'd7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 47;

    localparam logic [31:0] MS_SCALE = 32'd65536000;
    localparam int          NUM_W    = 50;
    localparam logic [5:0]  DIV_STEPS = 6'(NUM_W);
    localparam logic [80:0] KI_CAP   = 81'h4000_0000_0000_0000;

    localparam logic signed [50:0] I_MAX = 51'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [50:0] I_MIN = -51'sh0_8000_0000_0000;

    localparam logic signed [15:0] OUT_MAX_RST = 16'sd32767;
    localparam logic [15:0]        MIN_DT_RST  = 16'd2000;
    localparam logic [14:0]        SETTLE_RST  = 15'd16;

    localparam int unsigned SETTLE_SLOPE_DEF = 65536;

endpackage

`default_nettype wire

[rtl/heater_pid_with_smoothed_derivative.sv]
// Heater PID controller with smoothed derivative and anti-windup.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// in        sink       in_valid/in_stall    temperature, target_temp, time_ms
// out       source     out_valid/out_stall  drive, busy_res, no_time_step,
//                                           error_value, integral_value, slope_value
// cfg       sink       cfg_we               cfg_index, cfg_data
//
// One item passes three setup steps, a 50-step restoring divider for the slope,
// five multiply steps and a final step; the one shared 32x32 multiplier serves
// the first two setup steps and all five multiply steps. The next item can be
// taken once the result is registered; an item with no elapsed time skips to ST_FIN.
// in_stall stays high while an item is being worked on.
// The result sits in an output register, so a stalled result does not block
// the next accept; the final step waits only if that register is still full.
// Reset clears gains, bounds and controller state to their power-up values.

module heater_pid_with_smoothed_derivative #(
    parameter int unsigned SETTLE_SLOPE = hpid_pkg::SETTLE_SLOPE_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [hpid_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [hpid_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic signed [15:0]                  temperature,
    input  wire logic signed [15:0]                  target_temp,
    input  wire logic [31:0]                         time_ms,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [15:0]                       drive,
    output logic                                     busy_res,
    output logic                                     no_time_step,
    output logic signed [16:0]                       error_value,
    output logic signed [47:0]                       integral_value,
    output logic signed [31:0]                       slope_value
);
    import hpid_pkg::*;

    localparam logic signed [32:0] SLOPE_LIM = 33'(SETTLE_SLOPE);

    // Configuration
    logic [30:0]        kp_reg, ki_reg, kd_reg;
    logic signed [15:0] out_min_reg, out_max_reg;
    logic [15:0]        min_dt_reg;
    logic [46:0]        int_limit_reg;
    logic [14:0]        settle_reg;

    // Controller state
    state_t             state_reg, state_next;
    logic signed [47:0] integral_reg, integral_next;
    logic signed [15:0] prev_temp_reg, prev_temp_next;
    logic [31:0]        prev_time_reg, prev_time_next;
    logic signed [31:0] prev_slope_reg, prev_slope_next;
    logic               out_valid_reg, out_valid_next;

    // Working registers of one item
    logic signed [15:0] temp_reg, temp_next;
    logic signed [16:0] err_reg, err_next;
    logic signed [16:0] dtemp_reg, dtemp_next;
    logic [31:0]        dt_reg, dt_next;
    logic [31:0]        now_reg, now_next;
    logic               none_reg, none_next;
    logic               path_a_reg, path_a_next;
    logic signed [44:0] dtm_reg, dtm_next;
    logic [NUM_W-1:0]   dq_reg, dq_next;
    logic [31:0]        rem_reg, rem_next;
    logic [31:0]        div_reg, div_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic               qneg_reg, qneg_next;
    logic signed [31:0] slope_reg, slope_next;
    logic signed [47:0] cand_reg, cand_next;
    logic signed [49:0] p_reg, p_next;
    logic [63:0]        pl_reg, pl_next;
    logic signed [63:0] i_reg, i_next;

    // Shared multiplier
    logic [31:0]        mul_a, mul_b;
    logic               mul_en;
    logic [63:0]        prod_reg;

    // Output registers
    logic signed [15:0] drive_reg, drive_next;
    logic               busy_reg, busy_next;
    logic               nts_reg, nts_next;
    logic signed [16:0] errv_reg, errv_next;
    logic signed [47:0] intv_reg, intv_next;
    logic signed [31:0] slopev_reg, slopev_next;

    // Combinational helpers
    logic [31:0]        dtemp_mag, err_mag, slope_mag, pslope_mag;
    logic [47:0]        cand_mag;
    logic signed [48:0] term_b;
    logic signed [49:0] num;
    logic [32:0]        rem_shift;
    logic               rem_ge;
    logic signed [49:0] ie;
    logic signed [50:0] isum, isat;
    logic [80:0]        ki_full;
    logic [62:0]        ki_mag;
    logic signed [47:0] d_val;
    logic signed [65:0] sum, hi_b, lo_b, b_val;
    logic signed [31:0] b32;
    logic signed [31:0] busy_slope;
    logic [31:0]        dt_in;

    assign in_stall       = (state_reg != ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign drive          = drive_reg;
    assign busy_res       = busy_reg;
    assign no_time_step   = nts_reg;
    assign error_value    = errv_reg;
    assign integral_value = intv_reg;
    assign slope_value    = slopev_reg;

    assign dtemp_mag  = dtemp_reg[16] ? 32'(-dtemp_reg) : 32'(dtemp_reg);
    assign err_mag    = err_reg[16] ? 32'(-err_reg) : 32'(err_reg);
    assign slope_mag  = slope_reg[31] ? 32'(-slope_reg) : 32'(slope_reg);
    assign pslope_mag = prev_slope_reg[31] ? 32'(-prev_slope_reg) : 32'(prev_slope_reg);
    assign cand_mag   = cand_reg[47] ? 48'(-cand_reg) : 48'(cand_reg);
    assign dt_in      = time_ms - prev_time_reg;

    always_comb
    begin
        state_next      = state_reg;
        integral_next   = integral_reg;
        prev_temp_next  = prev_temp_reg;
        prev_time_next  = prev_time_reg;
        prev_slope_next = prev_slope_reg;
        out_valid_next  = out_valid_reg;
        temp_next       = temp_reg;
        err_next        = err_reg;
        dtemp_next      = dtemp_reg;
        dt_next         = dt_reg;
        now_next        = now_reg;
        none_next       = none_reg;
        path_a_next     = path_a_reg;
        dtm_next        = dtm_reg;
        dq_next         = dq_reg;
        rem_next        = rem_reg;
        div_next        = div_reg;
        cnt_next        = cnt_reg;
        qneg_next       = qneg_reg;
        slope_next      = slope_reg;
        cand_next       = cand_reg;
        p_next          = p_reg;
        pl_next         = pl_reg;
        i_next          = i_reg;
        drive_next      = drive_reg;
        busy_next       = busy_reg;
        nts_next        = nts_reg;
        errv_next       = errv_reg;
        intv_next       = intv_reg;
        slopev_next     = slopev_reg;
        mul_a           = '0;
        mul_b           = '0;
        mul_en          = 1'b0;

        term_b     = $signed({1'b0, prod_reg[47:0]});
        if (prev_slope_reg[31])
        begin
            term_b = -term_b;
        end
        num        = path_a_reg ? 50'(dtm_reg) : 50'(term_b) + 50'(dtm_reg);
        rem_shift  = {rem_reg, dq_reg[NUM_W-1]};
        rem_ge     = rem_shift >= {1'b0, div_reg};
        ie         = $signed({1'b0, prod_reg[48:0]});
        if (err_reg[16])
        begin
            ie = -ie;
        end
        isum       = 51'(integral_reg) + 51'(ie);
        isat       = isum;
        if (isum > I_MAX)
        begin
            isat = I_MAX;
        end
        if (isum < I_MIN)
        begin
            isat = I_MIN;
        end
        if (isat > $signed({4'b0, int_limit_reg}))
        begin
            isat = $signed({4'b0, int_limit_reg});
        end
        ki_full    = (81'(prod_reg) << 32) + 81'(pl_reg);
        ki_mag     = (ki_full > KI_CAP) ? KI_CAP[62:0] : ki_full[62:0];
        d_val      = $signed({2'b0, prod_reg[61:16]});
        if (slope_reg[31])
        begin
            d_val = -d_val;
        end
        sum        = 66'(p_reg) + 66'(i_reg) - 66'(d_val);
        hi_b       = 66'($signed({out_max_reg, 16'h0000}));
        lo_b       = 66'($signed({out_min_reg, 16'h0000}));
        b_val      = (sum > hi_b) ? hi_b : sum;
        if (b_val < lo_b)
        begin
            b_val = lo_b;
        end
        b32        = b_val[31:0];
        busy_slope = none_reg ? prev_slope_reg : slope_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    temp_next  = temperature;
                    err_next   = 17'(target_temp) - 17'(temperature);
                    dtemp_next = 17'(temperature) - 17'(prev_temp_reg);
                    dt_next    = dt_in;
                    now_next   = time_ms;
                    none_next  = (dt_in == 32'd0);
                    state_next = (dt_in == 32'd0) ? ST_FIN : ST_MUL_DT;
                end
            end
            ST_MUL_DT:
            begin
                mul_a       = dtemp_mag;
                mul_b       = MS_SCALE;
                mul_en      = 1'b1;
                path_a_next = dt_reg >= 32'(min_dt_reg);
                state_next  = ST_MUL_PS;
            end
            ST_MUL_PS:
            begin
                dtm_next   = dtemp_reg[16] ? -$signed({1'b0, prod_reg[43:0]})
                                           : $signed({1'b0, prod_reg[43:0]});
                mul_a      = pslope_mag;
                mul_b      = 32'(min_dt_reg - dt_reg[15:0]);
                mul_en     = 1'b1;
                state_next = ST_DIV_LOAD;
            end
            ST_DIV_LOAD:
            begin
                qneg_next  = num[NUM_W-1];
                dq_next    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
                rem_next   = '0;
                div_next   = path_a_reg ? dt_reg : 32'(min_dt_reg);
                cnt_next   = DIV_STEPS;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // one quotient bit a cycle
                rem_next = rem_ge ? 32'(rem_shift - {1'b0, div_reg}) : rem_shift[31:0];
                dq_next  = {dq_reg[NUM_W-2:0], rem_ge};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    state_next = ST_MUL_ERR;
                end
            end
            ST_MUL_ERR:
            begin
                // saturate the slope to 32 bits
                if (qneg_reg)
                begin
                    slope_next = (dq_reg > NUM_W'(33'h0_8000_0000)) ? 32'sh8000_0000
                                                                   : 32'(-dq_reg);
                end
                else
                begin
                    slope_next = (dq_reg > NUM_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                                 : 32'(dq_reg);
                end
                mul_a      = err_mag;
                mul_b      = dt_reg;
                mul_en     = 1'b1;
                state_next = ST_MUL_KP;
            end
            ST_MUL_KP:
            begin
                cand_next  = isat[47:0];
                mul_a      = err_mag;
                mul_b      = {1'b0, kp_reg};
                mul_en     = 1'b1;
                state_next = ST_MUL_KIL;
            end
            ST_MUL_KIL:
            begin
                p_next     = err_reg[16] ? -$signed({1'b0, prod_reg[48:0]})
                                         : $signed({1'b0, prod_reg[48:0]});
                mul_a      = {1'b0, ki_reg};
                mul_b      = cand_mag[31:0];
                mul_en     = 1'b1;
                state_next = ST_MUL_KIH;
            end
            ST_MUL_KIH:
            begin
                pl_next    = prod_reg;
                mul_a      = {1'b0, ki_reg};
                mul_b      = 32'(cand_mag[47:32]);
                mul_en     = 1'b1;
                state_next = ST_MUL_KD;
            end
            ST_MUL_KD:
            begin
                i_next     = cand_reg[47] ? -$signed({1'b0, ki_mag})
                                          : $signed({1'b0, ki_mag});
                mul_a      = {1'b0, kd_reg};
                mul_b      = slope_mag;
                mul_en     = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    nts_next       = none_reg;
                    errv_next      = err_reg;
                    busy_next      = ($signed({err_reg[16], err_reg}) >
                                      $signed({3'b0, settle_reg})) ||
                                     ($signed({err_reg[16], err_reg}) <
                                      -$signed({3'b0, settle_reg})) ||
                                     ($signed({busy_slope[31], busy_slope}) > SLOPE_LIM) ||
                                     ($signed({busy_slope[31], busy_slope}) < -SLOPE_LIM);
                    if (none_reg)
                    begin
                        drive_next  = out_min_reg;
                        intv_next   = integral_reg;
                        slopev_next = prev_slope_reg;
                    end
                    else
                    begin
                        drive_next  = b32[31:16] + 16'(b32[31] && (b32[15:0] != 16'h0000));
                        intv_next   = cand_reg;
                        slopev_next = slope_reg;
                        if (b_val == sum)
                        begin
                            integral_next = cand_reg;
                        end
                        prev_time_next  = now_reg;
                        prev_temp_next  = temp_reg;
                        prev_slope_next = slope_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg         <= '0;
            ki_reg         <= '0;
            kd_reg         <= '0;
            out_min_reg    <= '0;
            out_max_reg    <= OUT_MAX_RST;
            min_dt_reg     <= MIN_DT_RST;
            int_limit_reg  <= '0;
            settle_reg     <= SETTLE_RST;
            state_reg      <= ST_IDLE;
            integral_reg   <= '0;
            prev_temp_reg  <= '0;
            prev_time_reg  <= '0;
            prev_slope_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            integral_reg   <= integral_next;
            prev_temp_reg  <= prev_temp_next;
            prev_time_reg  <= prev_time_next;
            prev_slope_reg <= prev_slope_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_KP:        kp_reg        <= cfg_data[30:0];
                    CFG_KI:        ki_reg        <= cfg_data[30:0];
                    CFG_KD:        kd_reg        <= cfg_data[30:0];
                    CFG_OUT_MIN:   out_min_reg   <= cfg_data[15:0];
                    CFG_OUT_MAX:   out_max_reg   <= cfg_data[15:0];
                    CFG_MIN_DT:    min_dt_reg    <= cfg_data[15:0];
                    CFG_INT_LIMIT: int_limit_reg <= cfg_data[46:0];
                    CFG_SETTLE:    settle_reg    <= cfg_data[14:0];
                    default:       ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        temp_reg   <= temp_next;
        err_reg    <= err_next;
        dtemp_reg  <= dtemp_next;
        dt_reg     <= dt_next;
        now_reg    <= now_next;
        none_reg   <= none_next;
        path_a_reg <= path_a_next;
        dtm_reg    <= dtm_next;
        dq_reg     <= dq_next;
        rem_reg    <= rem_next;
        div_reg    <= div_next;
        cnt_reg    <= cnt_next;
        qneg_reg   <= qneg_next;
        slope_reg  <= slope_next;
        cand_reg   <= cand_next;
        p_reg      <= p_next;
        pl_reg     <= pl_next;
        i_reg      <= i_next;
        drive_reg  <= drive_next;
        busy_reg   <= busy_next;
        nts_reg    <= nts_next;
        errv_reg   <= errv_next;
        intv_reg   <= intv_next;
        slopev_reg <= slopev_next;
        if (mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
    end

endmodule

`default_nettype wire
